@@ rtl/core/c2p_pkg.sv @@
`timescale 1ns / 1ps

package c2p_pkg;

    // Rotation datapath: coordinates are scaled so that the input MSB lands on bit 60.
    localparam int CORDIC_W = 64;
    localparam int GUARD_TOP = 61;
    // Angle accumulator in units of pi/2^30.
    localparam int ANGLE_W = 32;
    localparam int MAG_W = 16;
    localparam int PHASE_W = 17;
    localparam int ROUND_SHIFT = 15;

    localparam logic signed [PHASE_W-1:0] PH_PI = 17'sd32768;
    localparam logic signed [PHASE_W-1:0] PH_HALF_PI = 17'sd16384;
    localparam logic signed [PHASE_W-1:0] PH_NEG_HALF_PI = -17'sd16384;
    localparam logic signed [PHASE_W-1:0] PH_NEG_PI = -17'sd32768;
    localparam logic signed [PHASE_W-1:0] PH_ZERO = 17'sd0;
    localparam logic signed [ANGLE_W-1:0] Z_HALF_PI = 32'sd536870912;

    // atan(2^-i) in units of pi/2^30, rounded to nearest.
    localparam logic [29:0] ATAN_UNITS [32] = '{
        30'd268435456, 30'd158466703, 30'd83729454, 30'd42502378, 30'd21333666,
        30'd10677233, 30'd5339919, 30'd2670123, 30'd1335082, 30'd667543,
        30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861, 30'd10430,
        30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81,
        30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0, 30'd0
    };

    // Axis and origin cases bypass the rotation result.
    typedef struct packed {
        logic                        special;
        logic signed [PHASE_W-1:0]   phase;
    } t_side;

endpackage

@@ rtl/core/c2p_prep.sv @@
`timescale 1ns / 1ps

module c2p_prep
    import c2p_pkg::*;
#(
    parameter int INPUT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [INPUT_WIDTH-1:0]     i_x_coord,
    input  logic signed [INPUT_WIDTH-1:0]     i_y_coord,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [CORDIC_W-1:0]        o_x,
    output logic signed [CORDIC_W-1:0]        o_y,
    output logic signed [ANGLE_W-1:0]         o_z,
    output logic [2*INPUT_WIDTH-1:0]          o_rem,
    output t_side                             o_side
);

    localparam int W = INPUT_WIDTH;
    localparam int GS = GUARD_TOP - INPUT_WIDTH;

    logic r_v0, r_v1, r_v2;
    logic w_rdy0, w_rdy1, w_rdy2;

    logic [W-1:0] r_ax, r_ay;
    logic [2*W-1:0] r_sqx, r_sqy, r_sum;
    logic signed [CORDIC_W-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic signed [ANGLE_W-1:0] r_z0, r_z1, r_z2;
    t_side r_s0, r_s1, r_s2;

    logic signed [CORDIC_W-1:0] n_x, n_y, w_xs, w_ys;
    logic signed [ANGLE_W-1:0] n_z;
    logic signed [W:0] w_xe, w_ye, w_xn, w_yn;
    logic [W-1:0] n_ax, n_ay;
    t_side n_side;
    logic w_x_zero, w_y_zero;

    assign w_rdy2 = !r_v2 || i_ready;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;

    always_comb begin
        w_xs = CORDIC_W'(i_x_coord) <<< GS;
        w_ys = CORDIC_W'(i_y_coord) <<< GS;
        // Fold the left half plane onto the right one with a quarter turn.
        if (i_x_coord[W-1]) begin
            if (!i_y_coord[W-1]) begin
                n_x = w_ys;
                n_y = -w_xs;
                n_z = Z_HALF_PI;
            end else begin
                n_x = -w_ys;
                n_y = w_xs;
                n_z = -Z_HALF_PI;
            end
        end else begin
            n_x = w_xs;
            n_y = w_ys;
            n_z = '0;
        end

        w_xe = (W+1)'(i_x_coord);
        w_ye = (W+1)'(i_y_coord);
        w_xn = -w_xe;
        w_yn = -w_ye;
        n_ax = i_x_coord[W-1] ? w_xn[W-1:0] : w_xe[W-1:0];
        n_ay = i_y_coord[W-1] ? w_yn[W-1:0] : w_ye[W-1:0];

        w_x_zero = (i_x_coord == '0);
        w_y_zero = (i_y_coord == '0);
        n_side.special = w_x_zero || w_y_zero;
        if (w_x_zero) begin
            if (w_y_zero) begin
                n_side.phase = PH_ZERO;
            end else if (i_y_coord[W-1]) begin
                n_side.phase = PH_NEG_HALF_PI;
            end else begin
                n_side.phase = PH_HALF_PI;
            end
        end else if (w_y_zero && i_x_coord[W-1]) begin
            n_side.phase = PH_PI;
        end else begin
            n_side.phase = PH_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= i_valid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_x0 <= n_x;
            r_y0 <= n_y;
            r_z0 <= n_z;
            r_s0 <= n_side;
        end
        if (w_rdy1 && r_v0) begin
            r_sqx <= (2*W)'(r_ax) * (2*W)'(r_ax);
            r_sqy <= (2*W)'(r_ay) * (2*W)'(r_ay);
            r_x1 <= r_x0;
            r_y1 <= r_y0;
            r_z1 <= r_z0;
            r_s1 <= r_s0;
        end
        if (w_rdy2 && r_v1) begin
            r_sum <= r_sqx + r_sqy;
            r_x2 <= r_x1;
            r_y2 <= r_y1;
            r_z2 <= r_z1;
            r_s2 <= r_s1;
        end
    end

    assign o_valid = r_v2;
    assign o_x = r_x2;
    assign o_y = r_y2;
    assign o_z = r_z2;
    assign o_rem = r_sum;
    assign o_side = r_s2;

endmodule

@@ rtl/core/c2p_cell.sv @@
`timescale 1ns / 1ps

module c2p_cell
    import c2p_pkg::*;
#(
    parameter int INPUT_WIDTH = 16,
    parameter int STEP = 0,
    parameter bit ROT_EN = 1'b1,
    parameter bit ROOT_EN = 1'b1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [CORDIC_W-1:0]        i_x,
    input  logic signed [CORDIC_W-1:0]        i_y,
    input  logic signed [ANGLE_W-1:0]         i_z,
    input  logic [2*INPUT_WIDTH-1:0]          i_rem,
    input  logic [2*INPUT_WIDTH-1:0]          i_res,
    input  t_side                             i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [CORDIC_W-1:0]        o_x,
    output logic signed [CORDIC_W-1:0]        o_y,
    output logic signed [ANGLE_W-1:0]         o_z,
    output logic [2*INPUT_WIDTH-1:0]          o_rem,
    output logic [2*INPUT_WIDTH-1:0]          o_res,
    output t_side                             o_side
);

    localparam int RW = 2 * INPUT_WIDTH;
    localparam int RSH = ROOT_EN ? 2 * (INPUT_WIDTH - 1 - STEP) : 0;
    localparam logic [RW-1:0] ROOT_BIT = RW'(1) << RSH;
    localparam logic signed [ANGLE_W-1:0] STEP_ANGLE = ANGLE_W'(ATAN_UNITS[STEP % 32]);

    logic r_valid;
    logic signed [CORDIC_W-1:0] r_x, r_y, n_x, n_y, w_dx, w_dy;
    logic signed [ANGLE_W-1:0] r_z, n_z;
    logic [RW-1:0] r_rem, r_res, n_rem, n_res, w_trial;
    t_side r_side;
    logic w_up;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_dx = i_y >>> STEP;
        w_dy = i_x >>> STEP;
        // Rotate clockwise while y is above the axis, otherwise counterclockwise.
        w_up = !i_y[CORDIC_W-1] && (i_y != '0);
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        if (ROT_EN) begin
            if (w_up) begin
                n_x = i_x + w_dx;
                n_y = i_y - w_dy;
                n_z = i_z + STEP_ANGLE;
            end else begin
                n_x = i_x - w_dx;
                n_y = i_y + w_dy;
                n_z = i_z - STEP_ANGLE;
            end
        end

        // One digit of the restoring square root.
        w_trial = i_res + ROOT_BIT;
        n_rem = i_rem;
        n_res = i_res;
        if (ROOT_EN) begin
            if (i_rem >= w_trial) begin
                n_rem = i_rem - w_trial;
                n_res = (i_res >> 1) + ROOT_BIT;
            end else begin
                n_res = i_res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_rem <= n_rem;
            r_res <= n_res;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_rem = r_rem;
    assign o_res = r_res;
    assign o_side = r_side;

endmodule

@@ rtl/core/c2p_post.sv @@
`timescale 1ns / 1ps

module c2p_post
    import c2p_pkg::*;
#(
    parameter int INPUT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [ANGLE_W-1:0]         i_z,
    input  logic [2*INPUT_WIDTH-1:0]          i_rem,
    input  logic [2*INPUT_WIDTH-1:0]          i_res,
    input  t_side                             i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [MAG_W-1:0]                  o_magnitude,
    output logic signed [PHASE_W-1:0]         o_phase
);

    localparam int W = INPUT_WIDTH;
    localparam int SW = (W + 1 > MAG_W + 1) ? W + 1 : MAG_W + 1;
    localparam logic [SW-1:0] MAG_MAX = SW'(17'h0FFFF);

    logic r_valid;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic signed [PHASE_W-1:0] r_phase, n_phase;
    logic [W:0] w_round;
    logic [SW-1:0] w_wide;
    logic signed [ANGLE_W-1:0] w_zr, w_p;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // Round to nearest: step up when the remainder exceeds the floor root.
        w_round = {1'b0, i_res[W-1:0]} + (W+1)'(i_rem > i_res);
        w_wide = SW'(w_round);
        n_mag = (w_wide > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : w_wide[MAG_W-1:0];

        w_zr = i_z + ANGLE_W'(1 << (ROUND_SHIFT - 1));
        w_p = w_zr >>> ROUND_SHIFT;
        if (i_side.special) begin
            n_phase = i_side.phase;
        end else if (w_p > ANGLE_W'(PH_PI)) begin
            n_phase = PH_PI;
        end else if (w_p < ANGLE_W'(PH_NEG_PI)) begin
            n_phase = PH_NEG_PI;
        end else begin
            n_phase = w_p[PHASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag <= n_mag;
            r_phase <= n_phase;
        end
    end

    assign o_valid = r_valid;
    assign o_magnitude = r_mag;
    assign o_phase = r_phase;

endmodule

@@ rtl/core/cartesian_to_polar_unit.sv @@
// Channel  Handshake           Payload
// -------  ------------------  --------------------------------------------
// input    i_valid / o_ready   i_x_coord, i_y_coord (signed, INPUT_WIDTH)
// output   o_valid / i_ready   o_magnitude (16 bit), o_phase (signed 17 bit)
//
// One beat is taken every cycle unless a stalled output has backed the pipeline up. It
// has three setup stages (fold and magnitude, squares, sum), one cell per rotation or
// root digit, and the output register.
// Every stage holds its own valid bit and moves when the next one is empty or moving,
// so a stalled output only stops the beats queued behind it and bubbles close up.
// Reset (synchronous, active low) clears the valid bits only.
`timescale 1ns / 1ps

module cartesian_to_polar_unit
    import c2p_pkg::*;
#(
    parameter int INPUT_WIDTH = 16,
    parameter int ITERATIONS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [INPUT_WIDTH-1:0]     i_x_coord,
    input  logic signed [INPUT_WIDTH-1:0]     i_y_coord,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [MAG_W-1:0]                  o_magnitude,
    output logic signed [PHASE_W-1:0]         o_phase
);

    localparam int NCELL = (ITERATIONS > INPUT_WIDTH) ? ITERATIONS : INPUT_WIDTH;
    localparam int RW = 2 * INPUT_WIDTH;

    logic                       w_valid [NCELL+1];
    logic                       w_ready [NCELL+1];
    logic signed [CORDIC_W-1:0] w_x     [NCELL+1];
    logic signed [CORDIC_W-1:0] w_y     [NCELL+1];
    logic signed [ANGLE_W-1:0]  w_z     [NCELL+1];
    logic [RW-1:0]              w_rem   [NCELL+1];
    logic [RW-1:0]              w_res   [NCELL+1];
    t_side                      w_side  [NCELL+1];

    c2p_prep #(
        .INPUT_WIDTH(INPUT_WIDTH)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_x       (w_x[0]),
        .o_y       (w_y[0]),
        .o_z       (w_z[0]),
        .o_rem     (w_rem[0]),
        .o_side    (w_side[0])
    );

    assign w_res[0] = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        c2p_cell #(
            .INPUT_WIDTH(INPUT_WIDTH),
            .STEP       (k),
            .ROT_EN     (k < ITERATIONS),
            .ROOT_EN    (k < INPUT_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .i_rem   (w_rem[k]),
            .i_res   (w_res[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_res   (w_res[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    c2p_post #(
        .INPUT_WIDTH(INPUT_WIDTH)
    ) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[NCELL]),
        .o_ready     (w_ready[NCELL]),
        .i_z         (w_z[NCELL]),
        .i_rem       (w_rem[NCELL]),
        .i_res       (w_res[NCELL]),
        .i_side      (w_side[NCELL]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_magnitude (o_magnitude),
        .o_phase     (o_phase)
    );

endmodule
